/* hw/rtl/c08pg_pkg.sv */
// ----------------------------------------------------------------------------
// c08pg_pkg
// Shared constants, the pair template table and the queue item type of the
// c08 cell pair generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c08pg_pkg;

  localparam int unsigned COORD_W           = 8;
  localparam int unsigned IDX_W             = 24;
  localparam int unsigned CFG_DATA_W        = 9;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned NUM_TEMPLATES     = 14;
  localparam int unsigned NUM_CORNERS       = 8;
  localparam int unsigned TMPL_W            = $clog2(NUM_TEMPLATES);
  localparam int unsigned CORNER_W          = $clog2(NUM_CORNERS);
  localparam int unsigned MIN_CELLS         = 3;
  localparam int unsigned MAX_CELLS_DEFAULT = 256;
  localparam int unsigned FIFO_DEPTH        = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

  // Corner codes: bit 0 is +x, bit 1 is +y, bit 2 is +z.
  localparam logic [CORNER_W-1:0] PAIR_FIRST [NUM_TEMPLATES] = '{
    3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd3, 3'd0,
    3'd1, 3'd2, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0
  };
  localparam logic [CORNER_W-1:0] PAIR_SECOND [NUM_TEMPLATES] = '{
    3'd7, 3'd6, 3'd6, 3'd1, 3'd3, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd2, 3'd2, 3'd5, 3'd5, 3'd0
  };

  // One classified base cell as handed from the front end to the back end.
  typedef struct packed {
    logic                     bad;
    logic [NUM_TEMPLATES-1:0] emit_mask;
    logic [NUM_CORNERS-1:0]   halo;
    logic [IDX_W-1:0]         base_idx;
    logic [IDX_W-1:0]         step_y;
    logic [IDX_W-1:0]         step_z;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/c08pg_front.sv */
// ----------------------------------------------------------------------------
// c08pg_front
// Accepts base cells, checks range, classifies the eight block corners as
// halo or not, builds the emit mask and computes the base linear index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c08pg_front #(
  parameter int unsigned SZ_W = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          acc,
  input  wire logic [c08pg_pkg::COORD_W-1:0] base_x,
  input  wire logic [c08pg_pkg::COORD_W-1:0] base_y,
  input  wire logic [c08pg_pkg::COORD_W-1:0] base_z,
  input  wire logic [SZ_W-1:0]               cells_x,
  input  wire logic [SZ_W-1:0]               cells_y,
  input  wire logic [SZ_W-1:0]               cells_z,
  output logic [1:0]                         inflight,
  output logic                               push,
  output c08pg_pkg::entry_t                  push_entry
);

  localparam int unsigned CMP_W = ((SZ_W > c08pg_pkg::COORD_W) ? SZ_W : c08pg_pkg::COORD_W) + 1;
  localparam int unsigned T1_W  = c08pg_pkg::COORD_W + SZ_W + 1;
  localparam int unsigned B_W   = T1_W + SZ_W;
  localparam int unsigned P_W   = 2 * SZ_W;

  // Stage 1: captured coordinates.
  logic                          v1_r;
  logic [c08pg_pkg::COORD_W-1:0] bx1_r, by1_r, bz1_r;

  // Stage 2: classification and partial index.
  logic                                v2_r;
  logic                                bad2_r;
  logic [c08pg_pkg::NUM_TEMPLATES-1:0] mask2_r;
  logic [c08pg_pkg::NUM_CORNERS-1:0]   halo2_r;
  logic [T1_W-1:0]                     t1_r;
  logic [P_W-1:0]                      plane_r;
  logic [c08pg_pkg::COORD_W-1:0]       bx2_r;

  logic [CMP_W-1:0] bx_e, by_e, bz_e, cx_e, cy_e, cz_e;
  logic             hx0, hx1, hy0, hy1, hz0, hz1;
  logic             bad_nxt;
  logic [c08pg_pkg::NUM_CORNERS-1:0]   halo_nxt;
  logic [c08pg_pkg::NUM_TEMPLATES-1:0] mask_nxt;
  logic [T1_W-1:0]  t1_nxt;
  logic [P_W-1:0]   plane_nxt;
  logic [B_W-1:0]   base_full;

  always_comb begin
    bx_e = CMP_W'(bx1_r);
    by_e = CMP_W'(by1_r);
    bz_e = CMP_W'(bz1_r);
    cx_e = CMP_W'(cells_x);
    cy_e = CMP_W'(cells_y);
    cz_e = CMP_W'(cells_z);
    bad_nxt = (bx_e > cx_e - CMP_W'(2)) || (by_e > cy_e - CMP_W'(2)) ||
              (bz_e > cz_e - CMP_W'(2));
    // Halo flags of the low and high coordinate on each axis.
    hx0 = (bx_e == '0) || (bx_e == cx_e - CMP_W'(1));
    hx1 = (bx_e + CMP_W'(1) == cx_e - CMP_W'(1));
    hy0 = (by_e == '0) || (by_e == cy_e - CMP_W'(1));
    hy1 = (by_e + CMP_W'(1) == cy_e - CMP_W'(1));
    hz0 = (bz_e == '0) || (bz_e == cz_e - CMP_W'(1));
    hz1 = (bz_e + CMP_W'(1) == cz_e - CMP_W'(1));
    for (int c = 0; c < c08pg_pkg::NUM_CORNERS; c++) begin
      halo_nxt[c] = (c[0] ? hx1 : hx0) | (c[1] ? hy1 : hy0) | (c[2] ? hz1 : hz0);
    end
    for (int t = 0; t < c08pg_pkg::NUM_TEMPLATES; t++) begin
      mask_nxt[t] = !(halo_nxt[c08pg_pkg::PAIR_FIRST[t]] &&
                      halo_nxt[c08pg_pkg::PAIR_SECOND[t]]);
    end
    t1_nxt    = T1_W'(bz1_r) * T1_W'(cells_y) + T1_W'(by1_r);
    plane_nxt = P_W'(cells_x) * P_W'(cells_y);
    base_full = B_W'(t1_r) * B_W'(cells_x) + B_W'(bx2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      bx1_r <= base_x;
      by1_r <= base_y;
      bz1_r <= base_z;
    end
    if (v1_r) begin
      bad2_r  <= bad_nxt;
      mask2_r <= mask_nxt;
      halo2_r <= halo_nxt;
      t1_r    <= t1_nxt;
      plane_r <= plane_nxt;
      bx2_r   <= bx1_r;
    end
  end

  always_comb begin
    inflight             = {1'b0, v1_r} + {1'b0, v2_r};
    push                 = v2_r;
    push_entry.bad       = bad2_r;
    push_entry.emit_mask = mask2_r;
    push_entry.halo      = halo2_r;
    push_entry.base_idx  = c08pg_pkg::IDX_W'(base_full);
    push_entry.step_y    = c08pg_pkg::IDX_W'(cells_x);
    push_entry.step_z    = c08pg_pkg::IDX_W'(plane_r);
  end

endmodule

`default_nettype wire

/* hw/rtl/c08pg_fifo.sv */
// ----------------------------------------------------------------------------
// c08pg_fifo
// Short queue of classified base cells between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c08pg_fifo #(
  parameter int unsigned DEPTH = c08pg_pkg::FIFO_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire c08pg_pkg::entry_t        push_entry,
  input  wire logic                     pop,
  output logic                          head_valid,
  output c08pg_pkg::entry_t             head_entry,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  c08pg_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  always_comb begin
    do_pop     = pop && (count_r != '0);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_entry = mem[rd_ptr_r];
  assign count      = count_r;

endmodule

`default_nettype wire

/* hw/rtl/c08pg_back.sv */
// ----------------------------------------------------------------------------
// c08pg_back
// Walks the emit mask of one base cell, one template a cycle while the output
// is not stalled, and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c08pg_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire c08pg_pkg::entry_t             head_entry,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [c08pg_pkg::IDX_W-1:0]        out_first_cell,
  output logic [c08pg_pkg::IDX_W-1:0]        out_second_cell,
  output logic                               out_single_cell,
  output logic                               out_last,
  output logic                               out_bad_base
);

  localparam int unsigned IW = c08pg_pkg::IDX_W;

  logic                                active_r, active_nxt;
  logic                                bad_r;
  logic [c08pg_pkg::NUM_TEMPLATES-1:0] mask_r, mask_nxt;
  logic [c08pg_pkg::NUM_CORNERS-1:0]   halo_r;
  logic [IW-1:0]                       base_r, sy_r, sz_r;

  logic                                out_valid_r, out_valid_nxt;
  logic [IW-1:0]                       first_r, second_r;
  logic                                single_r, last_r, badout_r;

  logic                                emit, finish, load;
  logic [c08pg_pkg::TMPL_W-1:0]        sel;
  logic [c08pg_pkg::CORNER_W-1:0]      ca, cb, cf, cs;
  logic [IW-1:0]                       idx_f, idx_s;
  logic                                single_nxt, last_nxt;

  function automatic logic [c08pg_pkg::IDX_W-1:0] corner_idx(
    input logic [c08pg_pkg::IDX_W-1:0]    b,
    input logic [c08pg_pkg::IDX_W-1:0]    sy,
    input logic [c08pg_pkg::IDX_W-1:0]    sz,
    input logic [c08pg_pkg::CORNER_W-1:0] c
  );
    logic [c08pg_pkg::IDX_W-1:0] r;
    r = b + c08pg_pkg::IDX_W'(c[0]) + (c[1] ? sy : '0) + (c[2] ? sz : '0);
    return r;
  endfunction

  always_comb begin
    sel = '0;
    for (int i = c08pg_pkg::NUM_TEMPLATES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = c08pg_pkg::TMPL_W'(i);
      end
    end
    ca    = c08pg_pkg::PAIR_FIRST[sel];
    cb    = c08pg_pkg::PAIR_SECOND[sel];
    // The non-halo corner goes first.
    cf    = halo_r[ca] ? cb : ca;
    cs    = halo_r[ca] ? ca : cb;
    idx_f = corner_idx(base_r, sy_r, sz_r, cf);
    idx_s = corner_idx(base_r, sy_r, sz_r, cs);
    single_nxt = (ca == cb);

    mask_nxt = mask_r;
    mask_nxt[sel] = 1'b0;

    emit   = active_r && (!out_valid_r || !out_stall);
    finish = emit && (bad_r || (mask_nxt == '0));
    last_nxt = bad_r || (mask_nxt == '0);
    load   = head_valid && (!active_r || finish);
    pop    = load;

    if (load) begin
      active_nxt = head_entry.bad || (head_entry.emit_mask != '0);
    end else if (finish) begin
      active_nxt = 1'b0;
    end else begin
      active_nxt = active_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bad_r  <= head_entry.bad;
      mask_r <= head_entry.emit_mask;
      halo_r <= head_entry.halo;
      base_r <= head_entry.base_idx;
      sy_r   <= head_entry.step_y;
      sz_r   <= head_entry.step_z;
    end else if (emit) begin
      mask_r <= mask_nxt;
    end
    if (emit) begin
      first_r  <= bad_r ? '0 : idx_f;
      second_r <= bad_r ? '0 : idx_s;
      single_r <= !bad_r && single_nxt;
      last_r   <= last_nxt;
      badout_r <= bad_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_cell  = first_r;
  assign out_second_cell = second_r;
  assign out_single_cell = single_r;
  assign out_last        = last_r;
  assign out_bad_base    = badout_r;

endmodule

`default_nettype wire

/* hw/rtl/c08_cell_pair_generator.sv */
// ----------------------------------------------------------------------------
// c08_cell_pair_generator
// Linked-cell c08 pair generator: one base cell in, its cell pairs out.
// ----------------------------------------------------------------------------
// Each accepted base cell yields between one and fourteen result items (one
// for an out-of-range base), one per clock on the output channel while it is
// not stalled. The back end walks the template mask one entry per cycle, again
// unless the output stalls, into a single result register. A base cell passes
// the stage-1 coordinate register, the stage-2 register (range check, halo
// classification and two of the three index multiplies) and the queue before
// it reaches the back end, and a four-entry queue lets new base cells be
// taken while earlier ones are still being expanded. Grid sizes written
// through the configuration port are clamped to [3, MAX_CELLS_PER_DIM] and may
// only be changed while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module c08_cell_pair_generator #(
  parameter int unsigned MAX_CELLS_PER_DIM = c08pg_pkg::MAX_CELLS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [c08pg_pkg::COORD_W-1:0]    in_base_x,
  input  wire logic [c08pg_pkg::COORD_W-1:0]    in_base_y,
  input  wire logic [c08pg_pkg::COORD_W-1:0]    in_base_z,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [c08pg_pkg::IDX_W-1:0]           out_first_cell,
  output logic [c08pg_pkg::IDX_W-1:0]           out_second_cell,
  output logic                                  out_single_cell,
  output logic                                  out_last,
  output logic                                  out_bad_base,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [c08pg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [c08pg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SZ_W  = $clog2(MAX_CELLS_PER_DIM + 1);
  localparam int unsigned CMP_W = ((SZ_W > c08pg_pkg::CFG_DATA_W) ? SZ_W
                                   : c08pg_pkg::CFG_DATA_W) + 1;
  localparam int unsigned CNT_W = $clog2(c08pg_pkg::FIFO_DEPTH + 1);

  logic [SZ_W-1:0]   cells_x_r, cells_y_r, cells_z_r;
  logic [SZ_W-1:0]   clamped;
  logic [CMP_W-1:0]  data_e;
  logic              cfg_wr, acc;

  logic [1:0]        inflight;
  logic              push, pop, head_valid;
  c08pg_pkg::entry_t push_entry, head_entry;
  logic [CNT_W-1:0]  q_count;

  always_comb begin
    data_e = CMP_W'(cfg_data);
    if (data_e < CMP_W'(c08pg_pkg::MIN_CELLS)) begin
      clamped = SZ_W'(c08pg_pkg::MIN_CELLS);
    end else if (data_e > CMP_W'(MAX_CELLS_PER_DIM)) begin
      clamped = SZ_W'(MAX_CELLS_PER_DIM);
    end else begin
      clamped = SZ_W'(cfg_data);
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= SZ_W'(c08pg_pkg::MIN_CELLS);
      cells_y_r <= SZ_W'(c08pg_pkg::MIN_CELLS);
      cells_z_r <= SZ_W'(c08pg_pkg::MIN_CELLS);
    end else if (cfg_wr) begin
      case (cfg_index)
        c08pg_pkg::REG_CELLS_X: cells_x_r <= clamped;
        c08pg_pkg::REG_CELLS_Y: cells_y_r <= clamped;
        c08pg_pkg::REG_CELLS_Z: cells_z_r <= clamped;
        default: ;
      endcase
    end
  end

  // Items still in the front pipeline are counted against queue space.
  assign in_stall = (CNT_W'(q_count) + CNT_W'(inflight)) >= CNT_W'(c08pg_pkg::FIFO_DEPTH);
  assign acc      = in_valid && !in_stall;

  c08pg_front #(
    .SZ_W (SZ_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .base_x     (in_base_x),
    .base_y     (in_base_y),
    .base_z     (in_base_z),
    .cells_x    (cells_x_r),
    .cells_y    (cells_y_r),
    .cells_z    (cells_z_r),
    .inflight   (inflight),
    .push       (push),
    .push_entry (push_entry)
  );

  c08pg_fifo #(
    .DEPTH (c08pg_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .count      (q_count)
  );

  c08pg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_entry      (head_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_cell  (out_first_cell),
    .out_second_cell (out_second_cell),
    .out_single_cell (out_single_cell),
    .out_last        (out_last),
    .out_bad_base    (out_bad_base)
  );

endmodule

`default_nettype wire

/* tb/tb_c08_cell_pair_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c08_cell_pair_generator
// Self-checking bench for the c08 cell pair generator. Base cells are sent in
// random bursts under a series of grid sizes, the result channel stalls on a
// random pattern, and every result item is compared with the cell pairs that
// the bench derives from its own copy of the c08 template table.
// ----------------------------------------------------------------------------
module tb_c08_cell_pair_generator;

  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned MAX_PRINTS      = 40;
  localparam int unsigned ITEMS_PER_PHASE = 44;

  // Index 3 decodes to no register; writes to it must change nothing.
  localparam logic [c08pg_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Corner codes: bit 0 is +x, bit 1 is +y, bit 2 is +z.
  localparam logic [c08pg_pkg::CORNER_W-1:0] NEAR_CORNER [c08pg_pkg::NUM_TEMPLATES] = '{
    3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd3, 3'd0,
    3'd1, 3'd2, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0
  };
  localparam logic [c08pg_pkg::CORNER_W-1:0] FAR_CORNER [c08pg_pkg::NUM_TEMPLATES] = '{
    3'd7, 3'd6, 3'd6, 3'd1, 3'd3, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd2, 3'd2, 3'd5, 3'd5, 3'd0
  };

  typedef struct packed {
    logic [c08pg_pkg::IDX_W-1:0] first_cell;
    logic [c08pg_pkg::IDX_W-1:0] second_cell;
    logic                        single_cell;
    logic                        last;
    logic                        bad_base;
  } cell_pair_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_LIGHT
  } stall_mode_t;

  class pair_scoreboard;
    int unsigned size_x;
    int unsigned size_y;
    int unsigned size_z;
    int unsigned errors;
    cell_pair_t  expected_pairs[$];

    function new();
      size_x = c08pg_pkg::MIN_CELLS;
      size_y = c08pg_pkg::MIN_CELLS;
      size_z = c08pg_pkg::MIN_CELLS;
      errors = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) begin
        $display("[%0t] ERROR: %s", $time, what);
      end
    endtask

    function int unsigned pending();
      return expected_pairs.size();
    endfunction

    function void expect_item(cell_pair_t item);
      expected_pairs.insert(expected_pairs.size(), item);
    endfunction

    function int unsigned clamp_size(logic [c08pg_pkg::CFG_DATA_W-1:0] value);
      if (value < c08pg_pkg::MIN_CELLS) return c08pg_pkg::MIN_CELLS;
      if (value > c08pg_pkg::MAX_CELLS_DEFAULT) return c08pg_pkg::MAX_CELLS_DEFAULT;
      return value;
    endfunction

    function void write_reg(logic [c08pg_pkg::CFG_IDX_W-1:0] index,
                            logic [c08pg_pkg::CFG_DATA_W-1:0] value);
      case (index)
        c08pg_pkg::REG_CELLS_X: size_x = clamp_size(value);
        c08pg_pkg::REG_CELLS_Y: size_y = clamp_size(value);
        c08pg_pkg::REG_CELLS_Z: size_z = clamp_size(value);
        default: ;
      endcase
    endfunction

    function bit corner_is_halo(logic [c08pg_pkg::COORD_W-1:0] bx, by, bz,
                                logic [c08pg_pkg::CORNER_W-1:0] code);
      int unsigned x;
      int unsigned y;
      int unsigned z;
      x = bx + code[0];
      y = by + code[1];
      z = bz + code[2];
      return x == 0 || x == size_x - 1 || y == 0 || y == size_y - 1 ||
             z == 0 || z == size_z - 1;
    endfunction

    function logic [c08pg_pkg::IDX_W-1:0] corner_index(logic [c08pg_pkg::COORD_W-1:0] bx, by, bz,
                                                       logic [c08pg_pkg::CORNER_W-1:0] code);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] z;
      logic [63:0] linear;
      x = bx + code[0];
      y = by + code[1];
      z = bz + code[2];
      linear = (z * size_y + y) * size_x + x;
      return linear[c08pg_pkg::IDX_W-1:0];
    endfunction

    // Expands one accepted base cell into the result items it must produce.
    function void note_base(logic [c08pg_pkg::COORD_W-1:0] bx, by, bz);
      cell_pair_t                     found[$];
      cell_pair_t                     item;
      logic [c08pg_pkg::CORNER_W-1:0] a;
      logic [c08pg_pkg::CORNER_W-1:0] b;
      bit                             halo_a;
      bit                             halo_b;
      int                             t;
      if (bx > size_x - 2 || by > size_y - 2 || bz > size_z - 2) begin
        item = '0;
        item.last = 1'b1;
        item.bad_base = 1'b1;
        expect_item(item);
        return;
      end
      for (t = 0; t < c08pg_pkg::NUM_TEMPLATES; t++) begin
        a = NEAR_CORNER[t];
        b = FAR_CORNER[t];
        halo_a = corner_is_halo(bx, by, bz, a);
        halo_b = corner_is_halo(bx, by, bz, b);
        if (!(halo_a && halo_b)) begin
          item = '0;
          if (a == b) begin
            item.first_cell = corner_index(bx, by, bz, a);
            item.second_cell = item.first_cell;
            item.single_cell = 1'b1;
          end else if (halo_a) begin
            item.first_cell = corner_index(bx, by, bz, b);
            item.second_cell = corner_index(bx, by, bz, a);
          end else begin
            item.first_cell = corner_index(bx, by, bz, a);
            item.second_cell = corner_index(bx, by, bz, b);
          end
          found.insert(found.size(), item);
        end
      end
      foreach (found[k]) begin
        item = found[k];
        item.last = (k == found.size() - 1);
        expect_item(item);
      end
    endfunction

    task check_result(cell_pair_t got);
      cell_pair_t want;
      if (expected_pairs.size() == 0) begin
        report($sformatf("result with nothing expected: first=%0d second=%0d bad=%0b",
                         got.first_cell, got.second_cell, got.bad_base));
        return;
      end
      want = expected_pairs.pop_front();
      if (got.first_cell !== want.first_cell)
        report($sformatf("first_cell got %0d, expected %0d", got.first_cell, want.first_cell));
      if (got.second_cell !== want.second_cell)
        report($sformatf("second_cell got %0d, expected %0d",
                         got.second_cell, want.second_cell));
      if (got.single_cell !== want.single_cell)
        report($sformatf("single_cell got %0b, expected %0b",
                         got.single_cell, want.single_cell));
      if (got.last !== want.last)
        report($sformatf("last got %0b, expected %0b", got.last, want.last));
      if (got.bad_base !== want.bad_base)
        report($sformatf("bad_base got %0b, expected %0b", got.bad_base, want.bad_base));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [c08pg_pkg::COORD_W-1:0]    in_base_x = '0;
  logic [c08pg_pkg::COORD_W-1:0]    in_base_y = '0;
  logic [c08pg_pkg::COORD_W-1:0]    in_base_z = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [c08pg_pkg::IDX_W-1:0]      out_first_cell;
  logic [c08pg_pkg::IDX_W-1:0]      out_second_cell;
  logic                             out_single_cell;
  logic                             out_last;
  logic                             out_bad_base;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [c08pg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [c08pg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pair_scoreboard sb;
  int unsigned    burst_left = 0;
  int unsigned    quiet_cycles = 0;
  bit             hold_request = 1'b0;

  always #1 clk = ~clk;

  c08_cell_pair_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_base_x       (in_base_x),
    .in_base_y       (in_base_y),
    .in_base_z       (in_base_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_cell  (out_first_cell),
    .out_second_cell (out_second_cell),
    .out_single_cell (out_single_cell),
    .out_last        (out_last),
    .out_bad_base    (out_bad_base),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    if (rst_n && in_valid && !in_stall) sb.note_base(in_base_x, in_base_y, in_base_z);
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(cell_pair_t'({out_first_cell, out_second_cell, out_single_cell,
                                    out_last, out_bad_base}));
    end
  end

  // Ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned seg_left;
    stall_mode_t mode;
    bit          hold_done;
    seg_left = 0;
    mode = STALL_NONE;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        // Long hold-off so that the internal queue fills and the input stalls.
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode = stall_mode_t'($urandom_range(3, 0));
          seg_left = $urandom_range(60, 4);
        end
        seg_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_HALF:  out_stall <= ($urandom_range(1, 0) != 0);
          STALL_HEAVY: out_stall <= ($urandom_range(3, 0) != 0);
          default:     out_stall <= ($urandom_range(7, 0) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_base(logic [c08pg_pkg::COORD_W-1:0] bx, by, bz);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_base_x <= bx;
    in_base_y <= by;
    in_base_z <= bz;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  function automatic logic [c08pg_pkg::COORD_W-1:0] pick_coord(int unsigned size, bit in_range);
    int unsigned roll;
    if (!in_range) return c08pg_pkg::COORD_W'($urandom_range(255, size - 1));
    roll = $urandom_range(9, 0);
    if (roll == 0) return '0;
    if (roll == 1) return c08pg_pkg::COORD_W'(size - 2);
    return c08pg_pkg::COORD_W'($urandom_range(size - 2, 0));
  endfunction

  // Mostly in-range bases; about one in six has a single axis out of range.
  task automatic send_random(int unsigned count);
    int unsigned bad_axis;
    repeat (count) begin
      bad_axis = ($urandom_range(5, 0) == 0) ? $urandom_range(2, 0) : 3;
      send_base(pick_coord(sb.size_x, bad_axis != 0),
                pick_coord(sb.size_y, bad_axis != 1),
                pick_coord(sb.size_z, bad_axis != 2));
    end
  endtask

  // The first edge lets the last accepted base cell be noted before the
  // pending count is read.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_grid(logic [c08pg_pkg::CFG_DATA_W-1:0] sx, sy, sz, bit touch_spare);
    logic [c08pg_pkg::CFG_IDX_W-1:0]  regs[4];
    logic [c08pg_pkg::CFG_DATA_W-1:0] vals[4];
    int unsigned                      n;
    int unsigned                      k;
    regs = '{c08pg_pkg::REG_CELLS_X, c08pg_pkg::REG_CELLS_Y, c08pg_pkg::REG_CELLS_Z, REG_SPARE};
    vals = '{sx, sy, sz, c08pg_pkg::CFG_DATA_W'($urandom_range(511, 0))};
    n = touch_spare ? 4 : 3;
    for (k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [c08pg_pkg::CFG_DATA_W-1:0] rand_size(int unsigned hi, lo);
    return c08pg_pkg::CFG_DATA_W'($urandom_range(hi, lo));
  endfunction

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset grid of 3x3x3: only coordinates 0 and 1 are in range.
    send_base(8'd0, 8'd0, 8'd0);
    send_base(8'd1, 8'd1, 8'd1);
    send_base(8'd1, 8'd0, 8'd1);
    send_base(8'd2, 8'd1, 8'd1);
    send_base(8'd1, 8'd2, 8'd1);
    send_base(8'd1, 8'd1, 8'd255);
    send_base(8'd255, 8'd255, 8'd255);
    wait_idle();

    // Values above the maximum are clamped to it.
    set_grid(9'd511, 9'd257, 9'd256, 1'b0);
    send_base(8'd0, 8'd0, 8'd0);
    send_base(8'd254, 8'd254, 8'd254);
    send_base(8'd255, 8'd254, 8'd254);
    send_base(8'd0, 8'd0, 8'd255);
    send_base(8'd170, 8'd85, 8'd170);
    send_base(8'd85, 8'd170, 8'd85);
    send_base(8'd253, 8'd1, 8'd127);
    send_random(ITEMS_PER_PHASE);
    wait_idle();

    // Values below the minimum are clamped to three.
    set_grid(9'd0, 9'd1, 9'd2, 1'b0);
    send_random(ITEMS_PER_PHASE);
    wait_idle();

    set_grid(9'd3, 9'd256, 9'd4, 1'b1);
    send_random(10);
    hold_request = 1'b1;
    send_random(ITEMS_PER_PHASE - 10);
    wait_idle();

    set_grid(rand_size(12, 3), rand_size(12, 3), rand_size(12, 3), 1'b0);
    send_random(ITEMS_PER_PHASE);
    wait_idle();

    set_grid(rand_size(511, 0), rand_size(511, 0), rand_size(511, 0), 1'b1);
    send_random(ITEMS_PER_PHASE);
    wait_idle();

    set_grid(9'd255, 9'd3, 9'd130, 1'b0);
    send_random(ITEMS_PER_PHASE);
    wait_idle();

    set_grid(rand_size(256, 3), rand_size(256, 3), rand_size(256, 3), 1'b0);
    send_random(ITEMS_PER_PHASE);
    wait_idle();

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/c08pg_pkg.sv
hw/rtl/c08pg_front.sv
hw/rtl/c08pg_fifo.sv
hw/rtl/c08pg_back.sv
hw/rtl/c08_cell_pair_generator.sv
tb/tb_c08_cell_pair_generator.sv
